>>> hw/rtl/telr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the throttled event log ring.
// Holds the request and result structs, store port structs and slot arithmetic.
// Has no dependencies.

package telr_pkg;

  // Number of record slots in the ring.
  localparam int unsigned LogDepth = 24;
  localparam int unsigned IdxW     = $clog2(LogDepth);
  localparam int unsigned CntW     = $clog2(LogDepth + 1);

  // Field widths.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned RateW    = 24;
  localparam int unsigned DistW    = 16;
  localparam int unsigned StatW    = 2;
  localparam int unsigned RdIdxW   = 5;
  localparam int unsigned CountW   = 5;

  // Reset value of the minimum store interval in milliseconds.
  localparam logic [TimeW-1:0] MinIntervalRst = TimeW'(3000);

  // Wide enough for a slot index plus a read index.
  localparam int unsigned SumW = 6;

  typedef enum logic [1:0] {
    ActSample = 2'd0,
    ActClear  = 2'd1,
    ActRead   = 2'd2
  } telr_action_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [TimeW-1:0]        time_ms;
    logic [RateW-1:0]        rate_cpm;
    logic signed [DistW-1:0] distance;
    logic [StatW-1:0]        status_code;
    logic [RdIdxW-1:0]       read_index;
  } telr_in_t;

  typedef struct packed {
    logic                    logged;
    logic                    read_valid;
    logic [TimeW-1:0]        entry_time_ms;
    logic [RateW-1:0]        entry_rate_cpm;
    logic signed [DistW-1:0] entry_distance;
    logic [StatW-1:0]        entry_status;
    logic [CountW-1:0]       entry_count;
  } telr_out_t;

  // One stored record.
  typedef struct packed {
    logic [TimeW-1:0]        time_ms;
    logic [RateW-1:0]        rate_cpm;
    logic signed [DistW-1:0] distance;
    logic [StatW-1:0]        status;
  } telr_rec_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } telr_port_t;

  // Slot that lies off positions after base, wrapped once around the ring.
  // The caller only uses the result when base + off is below twice the depth.
  function automatic logic [IdxW-1:0] slot_add(logic [IdxW-1:0] base,
                                               logic [RdIdxW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(LogDepth)) begin
      sum = sum - SumW'(LogDepth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

>>> hw/rtl/telr_store.sv
`timescale 1ns / 1ps
// Record store of the event log ring: one write port and one registered read port.
// Depends on telr_pkg.

module telr_store (
  input  logic                 clk_i,
  input  telr_pkg::telr_port_t wr_i,
  input  telr_pkg::telr_rec_t  wdata_i,
  input  telr_pkg::telr_port_t rd_i,
  output telr_pkg::telr_rec_t  rdata_o
);

  telr_pkg::telr_rec_t mem_q [telr_pkg::LogDepth];
  telr_pkg::telr_rec_t rdata_q;

  // Slots have no reset; a slot is only read after it has been written.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wdata_i;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/throttled_event_log_ring.sv
`timescale 1ns / 1ps
// Throttled event log ring: a rate-limited measurement log kept in a ring of slots.
// Depends on telr_pkg and telr_store.
//
// Usage:
// Requests enter on the in_* channel (valid/ready). A sample request is stored
// when it is the first since reset or clear, when its status differs from the
// last stored status, or when at least min_interval_ms milliseconds (modulo
// 2^32) have passed since the last store. A full ring overwrites its oldest
// record. A clear request empties the log, and a read request returns the
// record at read_index counted from the oldest, with read_valid set when the
// index is below the held count. Every request yields exactly one result on
// the out_* channel, which always reports the count held after that request.
// The cfg_* channel writes min_interval_ms; it is always ready and should
// only be used while no request is in flight.
// The result is valid in the cycle after acceptance. One request is taken
// every cycle unless a result stalls; the limit is the single ring slot write
// or read done at the accepting clock edge. When the receiver stalls, the
// result is held in the output register and in_ready_o drops until taken.
// After reset the log is empty and min_interval_ms is 3000. The ring slots
// are not cleared and need no clearing pass: a read only reaches slots that
// have been written since the last clear.

module throttled_event_log_ring (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [telr_pkg::TimeW-1:0]  cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  telr_pkg::telr_in_t          in_data_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output telr_pkg::telr_out_t         out_data_o
);

  // Ring and throttle state.
  logic [telr_pkg::IdxW-1:0]  oldest_q, oldest_d;
  logic [telr_pkg::CntW-1:0]  held_q, held_d;
  logic [telr_pkg::TimeW-1:0] last_time_q, last_time_d;
  logic [telr_pkg::StatW-1:0] last_status_q, last_status_d;
  logic                       have_last_q, have_last_d;
  logic [telr_pkg::TimeW-1:0] min_interval_q;

  // Output register. The entry fields come from the store's read register,
  // which is loaded at the same edge as this one.
  logic                         out_valid_q;
  logic                         logged_q, logged_d;
  logic                         hit_q, hit_d;
  logic [telr_pkg::CountW-1:0]  count_q, count_d;

  logic accept;
  logic changed, elapsed, do_store, full;
  logic [telr_pkg::TimeW-1:0] delta;

  telr_pkg::telr_port_t wr_port, rd_port;
  telr_pkg::telr_rec_t  wdata, rdata;

  // The configuration register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // A new request is taken whenever the output register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The time difference wraps modulo 2^32, so a plain subtract is exact.
  assign delta   = in_data_i.time_ms - last_time_q;
  assign changed = !have_last_q || (in_data_i.status_code != last_status_q);
  assign elapsed = !have_last_q || (delta >= min_interval_q);
  assign full    = (held_q >= telr_pkg::CntW'(telr_pkg::LogDepth));

  assign wdata.time_ms  = in_data_i.time_ms;
  assign wdata.rate_cpm = in_data_i.rate_cpm;
  assign wdata.distance = in_data_i.distance;
  assign wdata.status   = in_data_i.status_code;

  always_comb begin
    oldest_d      = oldest_q;
    held_d        = held_q;
    last_time_d   = last_time_q;
    last_status_d = last_status_q;
    have_last_d   = have_last_q;
    do_store      = 1'b0;
    logged_d      = 1'b0;
    hit_d         = 1'b0;
    wr_port       = '0;
    rd_port       = '0;

    case (in_data_i.action)
      telr_pkg::ActSample: begin
        do_store = changed || elapsed;
        if (do_store) begin
          wr_port.en = 1'b1;
          if (full) begin
            // Overwrite the oldest record and move the oldest mark on by one.
            wr_port.addr = oldest_q;
            if (oldest_q == telr_pkg::IdxW'(telr_pkg::LogDepth - 1)) begin
              oldest_d = '0;
            end else begin
              oldest_d = oldest_q + telr_pkg::IdxW'(1);
            end
          end else begin
            wr_port.addr = telr_pkg::slot_add(oldest_q, telr_pkg::RdIdxW'(held_q));
            held_d       = held_q + telr_pkg::CntW'(1);
          end
          last_time_d   = in_data_i.time_ms;
          last_status_d = in_data_i.status_code;
          have_last_d   = 1'b1;
          logged_d      = 1'b1;
        end
      end
      telr_pkg::ActClear: begin
        held_d      = '0;
        oldest_d    = '0;
        have_last_d = 1'b0;
      end
      telr_pkg::ActRead: begin
        // Only positions below the held count are ever read.
        hit_d        = (telr_pkg::SumW'(in_data_i.read_index) < telr_pkg::SumW'(held_q));
        rd_port.en   = hit_d;
        rd_port.addr = telr_pkg::slot_add(oldest_q, in_data_i.read_index);
      end
      default: begin
        // The unused action code changes nothing and only reports the count.
      end
    endcase

    count_d = telr_pkg::CountW'(held_d);
  end

  // Nothing reaches the store unless the request is actually accepted.
  telr_pkg::telr_port_t wr_gated, rd_gated;
  always_comb begin
    wr_gated    = wr_port;
    rd_gated    = rd_port;
    wr_gated.en = wr_port.en && accept;
    rd_gated.en = rd_port.en && accept;
  end

  telr_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr_gated),
    .wdata_i (wdata),
    .rd_i    (rd_gated),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q       <= '0;
      held_q         <= '0;
      last_time_q    <= '0;
      last_status_q  <= '0;
      have_last_q    <= 1'b0;
      min_interval_q <= telr_pkg::MinIntervalRst;
      out_valid_q    <= 1'b0;
      logged_q       <= 1'b0;
      hit_q          <= 1'b0;
      count_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        min_interval_q <= cfg_data_i;
      end
      if (accept) begin
        oldest_q      <= oldest_d;
        held_q        <= held_d;
        last_time_q   <= last_time_d;
        last_status_q <= last_status_d;
        have_last_q   <= have_last_d;
        logged_q      <= logged_d;
        hit_q         <= hit_d;
        count_q       <= count_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Entry fields are zero unless the read found a held record.
  assign out_valid_o               = out_valid_q;
  assign out_data_o.logged         = logged_q;
  assign out_data_o.read_valid     = hit_q;
  assign out_data_o.entry_time_ms  = hit_q ? rdata.time_ms  : '0;
  assign out_data_o.entry_rate_cpm = hit_q ? rdata.rate_cpm : '0;
  assign out_data_o.entry_distance = hit_q ? rdata.distance : '0;
  assign out_data_o.entry_status   = hit_q ? rdata.status   : '0;
  assign out_data_o.entry_count    = count_q;

endmodule

>>> hw/rtl/telr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the throttled event log ring, bound to the top level.
// Depends on telr_pkg and throttled_event_log_ring.

module telr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input telr_pkg::telr_out_t out_data_o
);

  // A stalled result keeps its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A stalled result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while result stalled");

  // The held count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= telr_pkg::CountW'(telr_pkg::LogDepth))
    else $error("entry count above ring depth");

  // A stored sample and a read hit never come from the same request.
  a_logged_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.logged |-> !out_data_o.read_valid)
    else $error("logged and read_valid both set");

  // Entry fields are zero unless a read found a record.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.read_valid |->
      out_data_o.entry_time_ms == '0 && out_data_o.entry_rate_cpm == '0 &&
      out_data_o.entry_distance == '0 && out_data_o.entry_status == '0)
    else $error("entry fields set without a read hit");

endmodule

bind throttled_event_log_ring telr_checker u_telr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
